FILE: src/pressure_sensor_calibrate_and_map_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure sensor calibrate-and-map block
// Shared immediate-style wrappers around concurrent properties, clocked on
// clk and disabled while rst_n is low. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_CALIBRATE_AND_MAP_DEFINES_SVH
`define PRESSURE_SENSOR_CALIBRATE_AND_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psc assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psc assertion failed");
`else
`define PSC_ASSERT_NOW(label, ante, cons)
`define PSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, register indexes, phase codes, reset values and shared types of
// the pressure sensor calibrate-and-map block.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 24;
    localparam int GROUP_SIZE = 10;
    localparam int FRAC_W     = 16;
    localparam int READS_W    = 8;
    localparam int MAP_W      = 25;
    localparam int PHASE_W    = 2;
    localparam int GSUM_W     = SAMPLE_W + $clog2(GROUP_SIZE);
    localparam int GCNT_W     = $clog2(GROUP_SIZE + 1);
    localparam int ACC_W      = LEVEL_W + READS_W;
    localparam int DIV_W      = ACC_W;
    localparam int DSR_W      = READS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int MUL_CNT_W  = $clog2(FRAC_W);
    localparam int DELTA_W    = LEVEL_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DELTA_FRAC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAL_READS   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEFAULT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEFAULT = CFG_IDX_W'(3);

    localparam logic [PHASE_W-1:0] PHASE_MIN = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_RUN = PHASE_W'(2);

    localparam logic [FRAC_W-1:0]  DELTA_FRAC_RST  = FRAC_W'(6554);
    localparam logic [READS_W-1:0] CAL_READS_RST   = READS_W'(16);
    localparam logic [LEVEL_W-1:0] MIN_DEFAULT_RST = '0;
    localparam logic [LEVEL_W-1:0] MAX_DEFAULT_RST = '0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic signed [MAP_W-1:0]    map_t;

    // Status of a serial arithmetic unit: busy while iterating, done for
    // one cycle when the result is ready.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: src/psc_if.sv
// ----------------------------------------------------------------------------
// psc_in_if / psc_out_if
// Valid/ready channels for samples into the block and results out of it.
// ----------------------------------------------------------------------------
interface psc_in_if import psc_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t raw_sample;
    logic    restart;

    modport source (output valid, output raw_sample, output restart, input ready);
    modport sink   (input valid, input raw_sample, input restart, output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
    logic               valid;
    logic               ready;
    map_t               mapped_value;
    logic [PHASE_W-1:0] phase;
    logic               min_done;
    logic               max_done;
    logic               min_ok;
    logic               max_ok;
    map_t               full_range;

    modport source (output valid, output mapped_value, output phase, output min_done,
                    output max_done, output min_ok, output max_ok, output full_range,
                    input ready);
    modport sink   (input valid, input mapped_value, input phase, input min_done,
                    input max_done, input min_ok, input max_ok, input full_range,
                    output ready);
endinterface

FILE: src/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Bit-serial signed divider: one quotient bit per cycle, truncating toward
// zero. The divisor is a small positive count.
// ----------------------------------------------------------------------------
`include "pressure_sensor_calibrate_and_map_defines.svh"

module psc_div import psc_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0]        divisor,
    output logic signed [DIV_W-1:0] quotient,
    output unit_stat_t              stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DSR_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [DSR_W:0]       trial;
    logic                 fits;

    // The dividend shifts out of the top while quotient bits shift in below.
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DIV_W-1];
            dvd_next  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `PSC_ASSERT_NOW(a_div_start_idle, start, !busy_reg)

endmodule

FILE: src/psc_mul.sv
// ----------------------------------------------------------------------------
// psc_mul
// Bit-serial band multiplier: level times a Q0.16 fraction, truncated
// toward zero, one fraction bit per cycle with a shift-right accumulator.
// ----------------------------------------------------------------------------
module psc_mul import psc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  level_t                    level,
    input  logic [FRAC_W-1:0]         frac,
    output logic signed [DELTA_W-1:0] delta,
    output unit_stat_t                stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [LEVEL_W-1:0]   mcand_reg, mcand_next;
    logic [FRAC_W-1:0]    mplier_reg, mplier_next;
    logic [LEVEL_W-1:0]   hi_reg, hi_next;
    logic [LEVEL_W:0]     sum;

    // Low product bits drop out; after the last step hi holds product >> 16.
    assign sum = {1'b0, hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        hi_next     = hi_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            neg_next    = level[LEVEL_W-1];
            mcand_next  = level[LEVEL_W-1] ? LEVEL_W'(-level) : LEVEL_W'(level);
            mplier_next = frac;
            hi_next     = '0;
        end
        else if (busy_reg)
        begin
            hi_next     = sum[LEVEL_W:1];
            mplier_next = {1'b0, mplier_reg[FRAC_W-1:1]};
            cnt_next    = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        hi_reg     <= hi_next;
    end

    assign delta     = neg_reg ? -$signed({1'b0, hi_reg}) : $signed({1'b0, hi_reg});
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: src/pressure_sensor_calibrate_and_map.sv
// ----------------------------------------------------------------------------
// pressure_sensor_calibrate_and_map
// Load-cell sample mapper with min and max calibration phases.
// ----------------------------------------------------------------------------
// Samples arrive on sample_ch (raw_sample, restart); every sample gives one
// result on result_ch: the sample minus the min level, clamped to the range
// 0..full_range, together with the phase and the calibration status. Registers
// must be written on cfg_we/cfg_index/cfg_data only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// One sample is in work at a time. A sample that does not close a group of
// ten passes S_ACC and S_MAP: its result is loaded into the output register
// on leaving S_MAP, and the next sample can then be taken in S_IDLE. A sample
// that closes a group runs the shared bit-serial divider and the bit-serial
// band multiplier: one division and the multiplier in max calibration and for
// a group with no accepted average yet, a second division for the mean for a
// later group in min calibration, and can add a further division when it also
// finishes min calibration. Run-phase and restart samples pass only S_ACC and S_MAP.
//
// A result waits in the output register while result_ch is stalled; the next
// sample is still taken, and its result is held back until the register
// frees. Reset loads the register defaults and starts min calibration.
// ----------------------------------------------------------------------------
`include "pressure_sensor_calibrate_and_map_defines.svh"

module pressure_sensor_calibrate_and_map import psc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    psc_in_if.sink                sample_ch,
    psc_out_if.source             result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_AVG   = 3'd2;
    localparam logic [2:0] S_MEAN  = 3'd3;
    localparam logic [2:0] S_DELTA = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_MAP   = 3'd6;

    // Configuration registers
    logic [FRAC_W-1:0]  delta_frac_reg;
    logic [READS_W-1:0] cal_reads_reg;
    level_t             min_default_reg;
    level_t             max_default_reg;

    // Calibration state
    logic [2:0]                state_reg, state_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic signed [GSUM_W-1:0]  group_sum_reg, group_sum_next;
    logic [GCNT_W-1:0]         group_count_reg, group_count_next;
    logic signed [ACC_W-1:0]   accept_sum_reg, accept_sum_next;
    logic [READS_W-1:0]        accept_count_reg, accept_count_next;
    level_t                    peak_level_reg, peak_level_next;
    logic                      peak_valid_reg, peak_valid_next;
    logic [READS_W-1:0]        return_count_reg, return_count_next;
    level_t                    min_level_reg, min_level_next;
    level_t                    max_level_reg, max_level_next;
    logic                      min_flag_reg, min_flag_next;
    logic                      max_flag_reg, max_flag_next;

    // Item in work
    sample_t sample_reg, sample_next;
    logic    restart_reg, restart_next;
    level_t  avg_reg, avg_next;
    level_t  mean_reg, mean_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    map_t               out_mapped_reg, out_mapped_next;
    logic [PHASE_W-1:0] out_phase_reg, out_phase_next;
    logic               out_min_done_reg, out_min_done_next;
    logic               out_max_done_reg, out_max_done_next;
    logic               out_min_ok_reg, out_min_ok_next;
    logic               out_max_ok_reg, out_max_ok_next;
    map_t               out_range_reg, out_range_next;

    // Arithmetic units
    logic                      div_start;
    logic signed [DIV_W-1:0]   div_dividend;
    logic [DSR_W-1:0]          div_divisor;
    logic signed [DIV_W-1:0]   div_quot;
    unit_stat_t                div_stat;
    logic                      mul_start;
    level_t                    mul_level;
    logic signed [DELTA_W-1:0] mul_delta;
    unit_stat_t                mul_stat;

    // Helpers
    logic signed [GSUM_W-1:0] gsum_new;
    logic [GCNT_W-1:0]        gcnt_new;
    logic                     acc_hit;
    logic signed [ACC_W-1:0]  asum_new;
    logic [READS_W-1:0]       acnt_new;
    logic                     near_min;
    logic                     far_min;
    map_t                     map_diff;
    map_t                     map_range;
    map_t                     map_floor;

    function automatic logic [DELTA_W-1:0] abs_diff(input level_t a, input level_t b);
        logic signed [DELTA_W-1:0] d;
        d = DELTA_W'(a) - DELTA_W'(b);
        return d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
    endfunction

    // |x| < d never holds for a negative band.
    function automatic logic below_band(input logic [DELTA_W-1:0] mag,
                                        input logic signed [DELTA_W-1:0] band);
        return !band[DELTA_W-1] && (mag < DELTA_W'(band));
    endfunction

    // |x| > d always holds for a negative band.
    function automatic logic above_band(input logic [DELTA_W-1:0] mag,
                                        input logic signed [DELTA_W-1:0] band);
        return band[DELTA_W-1] || (mag > DELTA_W'(band));
    endfunction

    psc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    psc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .level (mul_level),
        .frac  (delta_frac_reg),
        .delta (mul_delta),
        .stat  (mul_stat)
    );

    assign gsum_new = group_sum_reg + GSUM_W'(sample_reg);
    assign gcnt_new = group_count_reg + GCNT_W'(1);
    assign acc_hit  = (mean_reg == '0) ||
                      below_band(abs_diff(avg_reg, mean_reg), mul_delta);
    assign asum_new = accept_sum_reg + (acc_hit ? ACC_W'(avg_reg) : '0);
    assign acnt_new = accept_count_reg + READS_W'(acc_hit);
    assign near_min = below_band(abs_diff(avg_reg, min_level_reg), mul_delta);
    assign far_min  = above_band(abs_diff(avg_reg, min_level_reg), mul_delta);

    assign map_diff  = MAP_W'(sample_reg) - MAP_W'(min_level_reg);
    assign map_range = MAP_W'(max_level_reg) - MAP_W'(min_level_reg);
    assign map_floor = map_diff[MAP_W-1] ? '0 : map_diff;

    assign sample_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        group_sum_next     = group_sum_reg;
        group_count_next   = group_count_reg;
        accept_sum_next    = accept_sum_reg;
        accept_count_next  = accept_count_reg;
        peak_level_next    = peak_level_reg;
        peak_valid_next    = peak_valid_reg;
        return_count_next  = return_count_reg;
        min_level_next     = min_level_reg;
        max_level_next     = max_level_reg;
        min_flag_next      = min_flag_reg;
        max_flag_next      = max_flag_reg;
        sample_next        = sample_reg;
        restart_next       = restart_reg;
        avg_next           = avg_reg;
        mean_next          = mean_reg;
        out_valid_next     = out_valid_reg && !result_ch.ready;
        out_mapped_next    = out_mapped_reg;
        out_phase_next     = out_phase_reg;
        out_min_done_next  = out_min_done_reg;
        out_max_done_next  = out_max_done_reg;
        out_min_ok_next    = out_min_ok_reg;
        out_max_ok_next    = out_max_ok_reg;
        out_range_next     = out_range_reg;
        div_start          = 1'b0;
        div_dividend       = '0;
        div_divisor        = '0;
        mul_start          = 1'b0;
        mul_level          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    sample_next  = sample_ch.raw_sample;
                    restart_next = sample_ch.restart;
                    state_next   = S_ACC;
                end
            end

            S_ACC:
            begin
                state_next = S_MAP;
                if (restart_reg)
                begin
                    phase_next        = PHASE_MIN;
                    group_sum_next    = '0;
                    group_count_next  = '0;
                    accept_sum_next   = '0;
                    accept_count_next = '0;
                    peak_level_next   = '0;
                    peak_valid_next   = 1'b0;
                    return_count_next = '0;
                    min_level_next    = min_default_reg;
                    max_level_next    = max_default_reg;
                    min_flag_next     = 1'b0;
                    max_flag_next     = 1'b0;
                end
                else if (phase_reg != PHASE_RUN)
                begin
                    if (gcnt_new == GCNT_W'(GROUP_SIZE))
                    begin
                        group_sum_next   = '0;
                        group_count_next = '0;
                        div_start        = 1'b1;
                        div_dividend     = DIV_W'(gsum_new);
                        div_divisor      = DSR_W'(GROUP_SIZE);
                        state_next       = S_AVG;
                    end
                    else
                    begin
                        group_sum_next   = gsum_new;
                        group_count_next = gcnt_new;
                    end
                end
            end

            S_AVG:
            begin
                if (div_stat.done)
                begin
                    avg_next = div_quot[LEVEL_W-1:0];
                    if (phase_reg == PHASE_MIN && accept_count_reg != '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = accept_sum_reg;
                        div_divisor  = accept_count_reg;
                        state_next   = S_MEAN;
                    end
                    else
                    begin
                        // Empty mean is zero; max calibration bands on min level.
                        mean_next  = '0;
                        mul_start  = 1'b1;
                        mul_level  = (phase_reg == PHASE_MIN) ? '0 : min_level_reg;
                        state_next = S_DELTA;
                    end
                end
            end

            S_MEAN:
            begin
                if (div_stat.done)
                begin
                    mean_next  = div_quot[LEVEL_W-1:0];
                    mul_start  = 1'b1;
                    mul_level  = div_quot[LEVEL_W-1:0];
                    state_next = S_DELTA;
                end
            end

            S_DELTA:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_MAP;
                    if (phase_reg == PHASE_MIN)
                    begin
                        accept_sum_next   = asum_new;
                        accept_count_next = acnt_new;
                        if (acnt_new >= cal_reads_reg)
                        begin
                            accept_sum_next   = '0;
                            accept_count_next = '0;
                            if (acnt_new == '0)
                            begin
                                min_level_next = '0;
                                min_flag_next  = 1'b1;
                                phase_next     = PHASE_MAX;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_dividend = asum_new;
                                div_divisor  = acnt_new;
                                state_next   = S_FIN;
                            end
                        end
                    end
                    else
                    begin
                        if (!peak_valid_reg)
                        begin
                            if (far_min)
                            begin
                                peak_level_next = avg_reg;
                                peak_valid_next = 1'b1;
                            end
                        end
                        else if (avg_reg > peak_level_reg)
                        begin
                            peak_level_next = avg_reg;
                        end
                        else if (near_min)
                        begin
                            return_count_next = return_count_reg + READS_W'(1);
                        end
                        if (return_count_next >= cal_reads_reg)
                        begin
                            max_level_next    = peak_valid_next ? peak_level_next
                                                                : max_default_reg;
                            peak_level_next   = '0;
                            peak_valid_next   = 1'b0;
                            return_count_next = '0;
                            max_flag_next     = 1'b1;
                            phase_next        = PHASE_RUN;
                        end
                    end
                end
            end

            S_FIN:
            begin
                if (div_stat.done)
                begin
                    min_level_next = div_quot[LEVEL_W-1:0];
                    min_flag_next  = 1'b1;
                    phase_next     = PHASE_MAX;
                    state_next     = S_MAP;
                end
            end

            S_MAP:
            begin
                // The result goes out against the levels left by this sample.
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_mapped_next   = (map_floor > map_range) ? map_range : map_floor;
                    out_phase_next    = phase_reg;
                    out_min_done_next = min_flag_reg;
                    out_max_done_next = max_flag_reg;
                    out_min_ok_next   = min_flag_reg && (min_level_reg != min_default_reg);
                    out_max_ok_next   = max_flag_reg && (max_level_reg != max_default_reg);
                    out_range_next    = map_range;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_frac_reg  <= DELTA_FRAC_RST;
            cal_reads_reg   <= CAL_READS_RST;
            min_default_reg <= MIN_DEFAULT_RST;
            max_default_reg <= MAX_DEFAULT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELTA_FRAC:  delta_frac_reg  <= cfg_data[FRAC_W-1:0];
                REG_CAL_READS:   cal_reads_reg   <= cfg_data[READS_W-1:0];
                REG_MIN_DEFAULT: min_default_reg <= cfg_data[LEVEL_W-1:0];
                REG_MAX_DEFAULT: max_default_reg <= cfg_data[LEVEL_W-1:0];
                default:         delta_frac_reg  <= delta_frac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PHASE_MIN;
            group_sum_reg    <= '0;
            group_count_reg  <= '0;
            accept_sum_reg   <= '0;
            accept_count_reg <= '0;
            peak_level_reg   <= '0;
            peak_valid_reg   <= 1'b0;
            return_count_reg <= '0;
            min_level_reg    <= MIN_DEFAULT_RST;
            max_level_reg    <= MAX_DEFAULT_RST;
            min_flag_reg     <= 1'b0;
            max_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            group_sum_reg    <= group_sum_next;
            group_count_reg  <= group_count_next;
            accept_sum_reg   <= accept_sum_next;
            accept_count_reg <= accept_count_next;
            peak_level_reg   <= peak_level_next;
            peak_valid_reg   <= peak_valid_next;
            return_count_reg <= return_count_next;
            min_level_reg    <= min_level_next;
            max_level_reg    <= max_level_next;
            min_flag_reg     <= min_flag_next;
            max_flag_reg     <= max_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg       <= sample_next;
        restart_reg      <= restart_next;
        avg_reg          <= avg_next;
        mean_reg         <= mean_next;
        out_mapped_reg   <= out_mapped_next;
        out_phase_reg    <= out_phase_next;
        out_min_done_reg <= out_min_done_next;
        out_max_done_reg <= out_max_done_next;
        out_min_ok_reg   <= out_min_ok_next;
        out_max_ok_reg   <= out_max_ok_next;
        out_range_reg    <= out_range_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.mapped_value = out_mapped_reg;
    assign result_ch.phase        = out_phase_reg;
    assign result_ch.min_done     = out_min_done_reg;
    assign result_ch.max_done     = out_max_done_reg;
    assign result_ch.min_ok       = out_min_ok_reg;
    assign result_ch.max_ok       = out_max_ok_reg;
    assign result_ch.full_range   = out_range_reg;

    `PSC_ASSERT_NOW(a_run_needs_flags, phase_reg == PHASE_RUN, min_flag_reg && max_flag_reg)
    `PSC_ASSERT_NOW(a_group_below_size, 1'b1, group_count_reg < GCNT_W'(GROUP_SIZE))
    `PSC_ASSERT_NEXT(a_transfer_starts_work, sample_ch.valid && sample_ch.ready, state_reg == S_ACC)

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the pressure sensor calibrate-and-map block.
// ----------------------------------------------------------------------------
// Sessions of load-cell samples walk the block through min calibration, max
// calibration and run, under several register settings. A predictor in this
// file follows every accepted sample and queues the result it must produce;
// the monitor compares each result transfer field by field with the oldest
// queued result. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import psc_pkg::*;

    localparam longint SAMPLE_MAX     = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
    localparam longint FRAC_ONE       = longint'(1) << FRAC_W;
    localparam int     SAMPLE_TARGET  = 1300;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 4000;

    typedef struct {
        sample_t raw;
        logic    restart;
    } sample_item_t;

    typedef struct {
        map_t               mapped;
        logic [PHASE_W-1:0] phase;
        logic               min_done;
        logic               max_done;
        logic               min_ok;
        logic               max_ok;
        map_t               full_range;
    } cal_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    psc_in_if  in_ch ();
    psc_out_if out_ch ();

    pressure_sensor_calibrate_and_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (in_ch),
        .result_ch (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_item_t sample_queue[$];
    cal_result_t  expected_results[$];
    int           items_queued   = 0;
    int           mismatches     = 0;
    int           send_idle_pct  = 15;
    int           recv_idle_pct  = 15;
    bit           hold_req       = 1'b0;
    bit           hold_done      = 1'b0;
    int           hold_left      = 0;
    int           quiet_cycles   = 0;

    // Predictor copy of the registers.
    longint cfg_frac    = DELTA_FRAC_RST;
    longint cfg_reads   = CAL_READS_RST;
    longint cfg_min_def = level_t'(MIN_DEFAULT_RST);
    longint cfg_max_def = level_t'(MAX_DEFAULT_RST);

    // Predictor copy of the calibration state.
    logic [PHASE_W-1:0] cal_phase;
    longint             grp_sum, acc_sum, peak_lvl, min_lvl, max_lvl;
    int                 grp_cnt, acc_cnt, ret_cnt;
    bit                 peak_seen, min_flag, max_flag;

    function automatic void restore_levels();
        cal_phase = PHASE_MIN;
        grp_sum   = 0;
        grp_cnt   = 0;
        acc_sum   = 0;
        acc_cnt   = 0;
        peak_lvl  = 0;
        peak_seen = 1'b0;
        ret_cnt   = 0;
        min_lvl   = cfg_min_def;
        max_lvl   = cfg_max_def;
        min_flag  = 1'b0;
        max_flag  = 1'b0;
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Acceptance band; a negative reference level gives a negative band.
    function automatic longint band(longint ref_level);
        return (ref_level * cfg_frac) / FRAC_ONE;
    endfunction

    function automatic void min_track(longint avg);
        longint mean;
        mean = (acc_cnt != 0) ? acc_sum / acc_cnt : 0;
        if (mean == 0 || mag(avg - mean) < band(mean))
        begin
            acc_sum += avg;
            acc_cnt++;
        end
        if (acc_cnt >= cfg_reads)
        begin
            min_lvl   = (acc_cnt != 0) ? acc_sum / acc_cnt : 0;
            acc_sum   = 0;
            acc_cnt   = 0;
            min_flag  = 1'b1;
            cal_phase = PHASE_MAX;
        end
    endfunction

    function automatic void max_track(longint avg);
        longint d;
        d = band(min_lvl);
        if (!peak_seen)
        begin
            if (mag(avg - min_lvl) > d)
            begin
                peak_lvl  = avg;
                peak_seen = 1'b1;
            end
        end
        else if (avg > peak_lvl)
            peak_lvl = avg;
        else if (mag(avg - min_lvl) < d)
            ret_cnt++;
        if (ret_cnt >= cfg_reads)
        begin
            max_lvl   = peak_seen ? peak_lvl : cfg_max_def;
            peak_lvl  = 0;
            peak_seen = 1'b0;
            ret_cnt   = 0;
            max_flag  = 1'b1;
            cal_phase = PHASE_RUN;
        end
    endfunction

    function automatic cal_result_t cal_map_step(sample_t raw, logic restart);
        cal_result_t r;
        longint      s, avg, mapped, range;
        s = raw;
        if (restart)
            restore_levels();
        else if (cal_phase != PHASE_RUN)
        begin
            grp_sum += s;
            grp_cnt++;
            if (grp_cnt >= GROUP_SIZE)
            begin
                avg     = grp_sum / GROUP_SIZE;
                grp_sum = 0;
                grp_cnt = 0;
                if (cal_phase == PHASE_MIN)
                    min_track(avg);
                else
                    max_track(avg);
            end
        end
        mapped = s - min_lvl;
        range  = max_lvl - min_lvl;
        if (mapped < 0)
            mapped = 0;
        if (mapped > range)
            mapped = range;
        r.mapped     = map_t'(mapped);
        r.phase      = cal_phase;
        r.min_done   = min_flag;
        r.max_done   = max_flag;
        r.min_ok     = min_flag && (min_lvl != cfg_min_def);
        r.max_ok     = max_flag && (max_lvl != cfg_max_def);
        r.full_range = map_t'(range);
        return r;
    endfunction

    // Sample driver: a new sample goes out once the previous one is taken.
    always @(posedge clk)
    begin : drive_samples
        sample_item_t item;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(cal_map_step(in_ch.raw_sample, in_ch.restart));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = sample_queue.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.raw_sample <= item.raw;
                    in_ch.restart    <= item.restart;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Four-state compare, so that an unknown output bit counts as a mismatch.
    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result monitor, with one long receiver hold-off on request.
    always @(posedge clk)
    begin : check_results
        cal_result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer: mapped_value %0d",
                           out_ch.mapped_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("mapped_value", want.mapped, out_ch.mapped_value);
                    check_field("phase", want.phase, out_ch.phase);
                    check_field("min_done", want.min_done, out_ch.min_done);
                    check_field("max_done", want.max_done, out_ch.max_done);
                    check_field("min_ok", want.min_ok, out_ch.min_ok);
                    check_field("max_ok", want.max_ok, out_ch.max_ok);
                    check_field("full_range", want.full_range, out_ch.full_range);
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pressure_sensor_calibrate_and_map test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic longint rand_sample();
        return sample_t'($urandom);
    endfunction

    function automatic void push_sample(longint value, bit restart);
        sample_item_t item;
        if (value > SAMPLE_MAX)
            value = SAMPLE_MAX;
        if (value < SAMPLE_MIN)
            value = SAMPLE_MIN;
        item.raw     = sample_t'(value);
        item.restart = restart;
        sample_queue.push_back(item);
        items_queued++;
    endfunction

    function automatic void queue_group(longint center, longint amp);
        repeat (GROUP_SIZE)
            push_sample(center + longint'($urandom_range(32'(2 * amp))) - amp, 1'b0);
    endfunction

    // One restart followed by a well-formed calibration run with random content,
    // or a burst of noise with stray restarts.
    task automatic queue_session();
        longint base, d, amp, lvl;
        int     reads_eff;
        while (sample_queue.size() > 20)
            @(negedge clk);
        push_sample(rand_sample(), 1'b1);
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(40, 10))
                push_sample(rand_sample(), $urandom_range(99) < 5);
        end
        else
        begin
            if ($urandom_range(99) < 10)
                base = -longint'($urandom_range(4000000, 1000));
            else
                base = $urandom_range(4000000, 50000);
            d         = mag(band(base));
            amp       = d / 3;
            reads_eff = (cfg_reads > 6) ? 3 : int'(cfg_reads);
            repeat (reads_eff + 1 + $urandom_range(1))
            begin
                // A stray group now and then exercises the rejection path.
                if ($urandom_range(99) < 10)
                    queue_group(base + 3 * d + 1000, amp);
                else
                    queue_group(base, amp);
            end
            lvl = base + d + amp + 1;
            repeat ($urandom_range(3, 1))
            begin
                lvl += $urandom_range(200000, 1);
                queue_group(lvl, amp);
            end
            repeat (reads_eff + 2)
            begin
                if ($urandom_range(99) < 10)
                    queue_group(lvl + $urandom_range(100000), amp);
                else
                    queue_group(base, amp);
            end
            repeat ($urandom_range(20, 5))
            begin
                if ($urandom_range(1))
                    push_sample(rand_sample(), $urandom_range(99) < 3);
                else
                    push_sample(base + longint'($urandom_range(32'(2 * d + 1000))) - 500,
                                1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        // Bits above a narrow register get random junk that must be ignored.
        if (idx == REG_DELTA_FRAC)
            data[CFG_DATA_W-1:FRAC_W] = (CFG_DATA_W - FRAC_W)'($urandom);
        else if (idx == REG_CAL_READS)
            data[CFG_DATA_W-1:READS_W] = (CFG_DATA_W - READS_W)'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELTA_FRAC:  cfg_frac    = data[FRAC_W-1:0];
            REG_CAL_READS:   cfg_reads   = data[READS_W-1:0];
            REG_MIN_DEFAULT: cfg_min_def = level_t'(data);
            REG_MAX_DEFAULT: cfg_max_def = level_t'(data);
            default: ;
        endcase
    endtask

    task automatic set_config(longint frac, longint reads, longint min_def, longint max_def);
        wait_drained();
        write_reg(REG_DELTA_FRAC, frac);
        write_reg(REG_CAL_READS, reads);
        write_reg(REG_MIN_DEFAULT, min_def);
        write_reg(REG_MAX_DEFAULT, max_def);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int sess;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.raw_sample = '0;
        in_ch.restart    = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_DELTA_FRAC;
        cfg_data         = '0;
        restore_levels();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (4)
            @(negedge clk);

        // Field extremes and restarts against the reset levels.
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(0, 1'b1);
        push_sample(-1, 1'b0);
        push_sample(1, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);

        // With zero reads each phase ends after one group. The second group sits
        // on min, so no peak is seen and max falls back to its default, which lies
        // below min: the full range turns negative and both ok flags stay low.
        set_config(6554, 0, 5000, -100);
        push_sample(rand_sample(), 1'b1);
        repeat (2 * GROUP_SIZE)
            push_sample(5000, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(4000, 1'b0);

        items_queued = 0;
        sess         = 0;
        while (items_queued < SAMPLE_TARGET)
        begin
            if (sess == 0)
                set_config(DELTA_FRAC_RST, 2, 0, 0);
            else if (sess == 3)
                set_config(65535, 1, SAMPLE_MAX, SAMPLE_MIN);
            else if (sess == 6)
                set_config(0, 255, SAMPLE_MIN, SAMPLE_MAX);
            else if (sess % 3 == 0)
                set_config($urandom_range(30000, 2000), $urandom_range(5),
                           $urandom_range(1) ? 0 : longint'(level_t'($urandom)),
                           $urandom_range(1) ? 0 : longint'(level_t'($urandom)));
            if (sess == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sess == 7)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 15;
            end
            queue_session();
            // Stall the receiver while a full session is still waiting to go in.
            if (sess == 1)
                hold_req = 1'b1;
            sess++;
        end

        wait_drained();
        repeat (40)
            @(posedge clk);
        if (mismatches == 0)
            $display("pressure_sensor_calibrate_and_map test passed");
        else
            $display("pressure_sensor_calibrate_and_map test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/psc_pkg.sv
src/psc_if.sv
src/psc_div.sv
src/psc_mul.sv
src/pressure_sensor_calibrate_and_map.sv
dv/tb_top.sv
